>>> rtl/ptbl_pkg.sv
// Shared types and constants for the paper-tape binary loader.
`default_nettype none

package ptbl_pkg;

    // Special tape byte values and frame masks.
    localparam logic [7:0]  BYTE_RUBOUT = 8'o377;
    localparam logic [7:0]  BYTE_EDGE   = 8'o200;
    localparam logic [7:0]  FIELD_BITS  = 8'o070;
    localparam logic [11:0] WORD_MASK   = 12'o7777;

    // Widths of the result fields.
    localparam int unsigned ADDR_W = 15;
    localparam int unsigned DATA_W = 12;

    // Parser phase; code three never occurs and is treated as leader.
    typedef enum logic [1:0] {
        PH_LEADER = 2'd0,
        PH_LOW    = 2'd1,
        PH_HIGH   = 2'd2
    } t_phase;

    // Kind of result item.
    typedef enum logic [1:0] {
        KIND_WRITE   = 2'd0,
        KIND_END_OK  = 2'd1,
        KIND_END_ERR = 2'd2
    } t_kind;

    // One result as it leaves the parser core.
    typedef struct packed {
        logic              valid;
        t_kind             kind;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/ptbl_parse_core.sv
// Parser state and the combinational step logic for one tape byte.
`default_nettype none

module ptbl_parse_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [7:0]       i_byte,
    output ptbl_pkg::t_result     o_result
);
    import ptbl_pkg::*;

    logic        r_skip_next,     n_skip_next;
    t_phase      r_phase,         n_phase;
    logic        r_finished,      n_finished;
    logic [7:0]  r_high_part,     n_high_part;
    logic [7:0]  r_low_part,      n_low_part;
    logic [11:0] r_running_sum,   n_running_sum;
    logic [11:0] r_load_origin,   n_load_origin;
    logic [2:0]  r_active_field,  n_active_field;
    logic [2:0]  r_pending_field, n_pending_field;

    logic [13:0] frame;
    logic [11:0] sum_diff;
    logic [7:0]  field_byte;

    // The frame overlaps the two bytes exactly as read from tape.
    assign frame      = {r_high_part, 6'b0} | {6'b0, r_low_part};
    assign sum_diff   = r_running_sum - frame[11:0];
    assign field_byte = i_byte & FIELD_BITS;

    // Next state and result for the byte being processed.
    always_comb begin
        n_skip_next     = r_skip_next;
        n_phase         = r_phase;
        n_finished      = r_finished;
        n_high_part     = r_high_part;
        n_low_part      = r_low_part;
        n_running_sum   = r_running_sum;
        n_load_origin   = r_load_origin;
        n_active_field  = r_active_field;
        n_pending_field = r_pending_field;
        o_result        = '0;
        o_result.kind   = KIND_WRITE;

        if (!i_step || r_finished) begin
            // Nothing to do; the tape has ended or no byte is present.
        end else if (r_skip_next) begin
            n_skip_next = 1'b0;
        end else if (i_byte == BYTE_RUBOUT) begin
            n_skip_next = 1'b1;
        end else if (i_byte > BYTE_EDGE) begin
            n_pending_field = field_byte[5:3];
        end else begin
            case (r_phase)
                PH_LOW: begin
                    n_low_part = i_byte;
                    n_phase    = PH_HIGH;
                end
                PH_HIGH: begin
                    if (i_byte == BYTE_EDGE) begin
                        // Trailer: the last frame is the checksum.
                        n_finished     = 1'b1;
                        o_result.valid = 1'b1;
                        o_result.kind  = (sum_diff != 12'd0) ? KIND_END_ERR : KIND_END_OK;
                    end else begin
                        n_running_sum = r_running_sum + {4'b0, r_low_part}
                                      + {4'b0, r_high_part};
                        if (frame[13:12] != 2'b00) begin
                            n_load_origin = frame[11:0];
                        end else begin
                            o_result.valid = 1'b1;
                            o_result.kind  = KIND_WRITE;
                            o_result.addr  = {r_active_field, r_load_origin};
                            o_result.data  = frame[11:0] & WORD_MASK;
                            n_load_origin  = r_load_origin + 12'd1;
                        end
                        n_active_field = r_pending_field;
                        n_high_part    = i_byte;
                        n_phase        = PH_LOW;
                    end
                end
                default: begin
                    // Leader: zero and edge bytes keep the leader going.
                    if (i_byte != 8'd0 && i_byte != BYTE_EDGE) begin
                        n_phase = PH_LOW;
                    end else begin
                        n_phase = PH_LEADER;
                    end
                    n_high_part = i_byte;
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_next     <= 1'b0;
            r_phase         <= PH_LEADER;
            r_finished      <= 1'b0;
            r_high_part     <= '0;
            r_low_part      <= '0;
            r_running_sum   <= '0;
            r_load_origin   <= '0;
            r_active_field  <= '0;
            r_pending_field <= '0;
        end else begin
            r_skip_next     <= n_skip_next;
            r_phase         <= n_phase;
            r_finished      <= n_finished;
            r_high_part     <= n_high_part;
            r_low_part      <= n_low_part;
            r_running_sum   <= n_running_sum;
            r_load_origin   <= n_load_origin;
            r_active_field  <= n_active_field;
            r_pending_field <= n_pending_field;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ptbl_out_reg.sv
// Output register holding one result until the receiver takes it.
`default_nettype none

module ptbl_out_reg (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_load,
    input  ptbl_pkg::t_result                 i_result,
    input  wire logic                         i_out_stall,
    output logic                              o_out_valid,
    output logic [1:0]                        o_result_kind,
    output logic [ptbl_pkg::ADDR_W-1:0]       o_write_address,
    output logic [ptbl_pkg::DATA_W-1:0]       o_write_data,
    output logic                              o_free
);
    import ptbl_pkg::*;

    logic              r_valid;
    t_kind             r_kind;
    logic [ADDR_W-1:0] r_addr;
    logic [DATA_W-1:0] r_data;

    // The register can take a new result when empty or being transferred.
    assign o_free = !r_valid || !i_out_stall;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_result.valid;
        end
    end

    // Payload only changes when a new result is loaded.
    always_ff @(posedge i_clk) begin
        if (i_load && i_result.valid) begin
            r_kind <= i_result.kind;
            r_addr <= i_result.addr;
            r_data <= i_result.data;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_result_kind   = r_kind;
    assign o_write_address = r_addr;
    assign o_write_data    = r_data;

endmodule

`default_nettype wire

>>> rtl/paper_tape_bin_loader.sv
// Top level of the paper-tape binary loader.
//
// Input channel: one raw tape byte per transfer on i_tape_byte, qualified by
// i_in_valid and held off by o_in_stall. Output channel: one result per
// transfer on o_result_kind, o_write_address and o_write_data, qualified by
// o_out_valid and held off by i_out_stall. A result is a memory write or the
// end of tape with the checksum verdict; most bytes produce no result.
// The byte is captured in an input register, then parsed by the step logic
// and the result is written into the output register. Throughput is one
// byte per cycle while the output register has room; the output register
// lets a new byte be taken while a finished result waits. When the receiver
// stalls with a result pending, the pipeline holds and o_in_stall rises once
// the input register is also full. Synchronous reset returns the parser to
// the leader phase with all sums, origin and field cleared and both
// registers empty. After the trailer all further bytes are accepted and
// discarded until reset.
`default_nettype none

module paper_tape_bin_loader (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [7:0]                   i_tape_byte,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [1:0]                        o_result_kind,
    output logic [ptbl_pkg::ADDR_W-1:0]       o_write_address,
    output logic [ptbl_pkg::DATA_W-1:0]       o_write_data
);
    import ptbl_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       out_free;
    logic       step;
    logic       in_take;
    t_result    step_result;

    // The stage advances whenever it holds a byte and the output register has room.
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_tape_byte;
        end
    end

    ptbl_parse_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_result (step_result)
    );

    ptbl_out_reg u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (out_free),
        .i_result        (step_result),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_result_kind   (o_result_kind),
        .o_write_address (o_write_address),
        .o_write_data    (o_write_data),
        .o_free          (out_free)
    );

endmodule

`default_nettype wire

>>> rtl/ptbl_checker.sv
// Port-level checks for the paper-tape binary loader, bound to the top level.
`default_nettype none

module ptbl_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_stall,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_stall,
    input wire logic [1:0]                   o_result_kind,
    input wire logic [ptbl_pkg::ADDR_W-1:0]  o_write_address,
    input wire logic [ptbl_pkg::DATA_W-1:0]  o_write_data
);
    import ptbl_pkg::*;

    logic r_ended;

    // Remember that an end-of-tape result has been transferred.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ended <= 1'b0;
        end else if (o_out_valid && !i_out_stall && o_result_kind != KIND_WRITE) begin
            r_ended <= 1'b1;
        end
    end

    // A stalled result stays valid.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled result dropped");

    // End results carry zero address and data.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind != KIND_WRITE) |->
            (o_write_address == '0 && o_write_data == '0))
        else $error("end result with nonzero payload");

    // Nothing follows the end of the tape.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ended |-> !o_out_valid)
        else $error("result after end of tape");

    // A new result appears only after a matching byte transfer.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result without a matching byte transfer");

endmodule

bind paper_tape_bin_loader ptbl_checker u_ptbl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_result_kind   (o_result_kind),
    .o_write_address (o_write_address),
    .o_write_data    (o_write_data)
);

`default_nettype wire

>>> verif/ptbl_load_checker.sv
// Checker that predicts and compares the results of the paper-tape binary loader.
`timescale 1ns / 1ps

module ptbl_load_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_stall,
    input  wire logic [7:0]                    i_tape_byte,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_stall,
    input  wire logic [1:0]                    i_result_kind,
    input  wire logic [ptbl_pkg::ADDR_W-1:0]   i_write_address,
    input  wire logic [ptbl_pkg::DATA_W-1:0]   i_write_data,
    output int                                 o_due_count,
    output int                                 o_fail_count
);
    import ptbl_pkg::*;

    // One predicted result of the loader.
    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_load_result;

    // Predicted results that have not been seen on the output yet.
    t_load_result results_due[$];
    int           mismatches = 0;

    // Private copy of the parser state.
    logic         skip_pending;
    t_phase       tape_phase;
    logic         tape_done;
    logic [7:0]   hi_byte;
    logic [7:0]   lo_byte;
    logic [11:0]  word_sum;
    logic [11:0]  origin;
    logic [2:0]   field_now;
    logic [2:0]   field_next;

    // Advances the parser by one tape byte and queues the result it causes.
    task automatic parse_tape_byte(input logic [7:0] b);
        logic [13:0]  frame;
        logic [11:0]  residue;
        t_load_result item;
        frame   = {hi_byte, 6'b0} | {6'b0, lo_byte};
        residue = word_sum - frame[11:0];
        if (tape_done) return;
        if (skip_pending) begin
            skip_pending = 1'b0;
            return;
        end
        // A rubout drops itself and the byte after it.
        if (b == BYTE_RUBOUT) begin
            skip_pending = 1'b1;
            return;
        end
        // Any other byte above the edge value selects the next field.
        if (b > BYTE_EDGE) begin
            field_next = b[5:3];
            return;
        end
        case (tape_phase)
            PH_LOW: begin
                lo_byte    = b;
                tape_phase = PH_HIGH;
            end
            PH_HIGH: begin
                if (b == BYTE_EDGE) begin
                    // The trailer: the last frame holds the checksum.
                    tape_done = 1'b1;
                    item.kind = (residue != 12'd0) ? KIND_END_ERR : KIND_END_OK;
                    item.addr = '0;
                    item.data = '0;
                    results_due.push_back(item);
                end else begin
                    word_sum = word_sum + lo_byte + hi_byte;
                    if (frame[13:12] != 2'b00) begin
                        origin = frame[11:0];
                    end else begin
                        item.kind = KIND_WRITE;
                        item.addr = {field_now, origin};
                        item.data = frame[11:0];
                        results_due.push_back(item);
                        origin = origin + 12'd1;
                    end
                    field_now  = field_next;
                    hi_byte    = b;
                    tape_phase = PH_LOW;
                end
            end
            default: begin
                // Leader: zero and edge bytes keep the parser waiting.
                tape_phase = (b != 8'd0 && b != BYTE_EDGE) ? PH_LOW : PH_LEADER;
                hi_byte    = b;
            end
        endcase
    endtask

    // Predict on every input transfer and compare every output transfer.
    always @(posedge i_clk) begin : watch
        t_load_result want;
        if (!i_rst_n) begin
            skip_pending = 1'b0;
            tape_phase   = PH_LEADER;
            tape_done    = 1'b0;
            hi_byte      = '0;
            lo_byte      = '0;
            word_sum     = '0;
            origin       = '0;
            field_now    = '0;
            field_next   = '0;
            results_due.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                parse_tape_byte(i_tape_byte);
            end
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    $error("unexpected result: kind %0d, address %0h, data %0h",
                           i_result_kind, i_write_address, i_write_data);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    if (i_result_kind !== want.kind) begin
                        $error("result_kind: expected %0d, actual %0d",
                               want.kind, i_result_kind);
                        mismatches++;
                    end
                    if (i_write_address !== want.addr) begin
                        $error("write_address: expected %0h, actual %0h",
                               want.addr, i_write_address);
                        mismatches++;
                    end
                    if (i_write_data !== want.data) begin
                        $error("write_data: expected %0h, actual %0h",
                               want.data, i_write_data);
                        mismatches++;
                    end
                end
            end
        end
        o_due_count  <= results_due.size();
        o_fail_count <= mismatches;
    end

endmodule

>>> verif/paper_tape_bin_loader_tb.sv
// Testbench top that feeds tape images to the paper-tape binary loader.
`timescale 1ns / 1ps

module paper_tape_bin_loader_tb;
    import ptbl_pkg::*;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [7:0]          tape_byte = 8'd0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [1:0]          result_kind;
    logic [ADDR_W-1:0]   write_address;
    logic [DATA_W-1:0]   write_data;
    int                  due_count;
    int                  fail_count;

    // The tape image to send and the checksum of its frames.
    logic [7:0]          tape_image[$];
    logic [11:0]         tape_sum  = '0;
    int                  bytes_taken = 0;
    bit                  calm = 1'b0;

    paper_tape_bin_loader u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_tape_byte     (tape_byte),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_result_kind   (result_kind),
        .o_write_address (write_address),
        .o_write_data    (write_data)
    );

    ptbl_load_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_tape_byte     (tape_byte),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_result_kind   (result_kind),
        .i_write_address (write_address),
        .i_write_data    (write_data),
        .o_due_count     (due_count),
        .o_fail_count    (fail_count)
    );

    // Clock generator.
    initial begin
        forever #5 clk = ~clk;
    end

    // Safety limit on the whole run.
    initial begin
        #2_000_000;
        $display("** paper_tape_bin_loader: FAILED **");
        $finish;
    end

    // Adds a field setting or a rubout with the byte it swallows.
    task automatic punch_noise();
        if ($urandom_range(1) == 1) begin
            tape_image.push_back(8'($urandom_range(8'o201, 8'o376)));
        end else begin
            tape_image.push_back(BYTE_RUBOUT);
            tape_image.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Adds one frame, optionally with noise between its two bytes.
    task automatic punch_frame(input logic [7:0] hi, input logic [7:0] lo, input bit noisy);
        tape_image.push_back(hi);
        if (noisy && $urandom_range(99) < 12) punch_noise();
        tape_image.push_back(lo);
        tape_sum = tape_sum + hi + lo;
    endtask

    // Receiver: random stalls, a calm stretch and one long hold-off.
    initial begin : receiver
        int hold_left;
        bit held_once;
        hold_left = 0;
        held_once = 1'b0;
        forever begin
            @(negedge clk);
            if (!held_once && bytes_taken >= 700) begin
                held_once = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= !calm && ($urandom_range(99) < 24);
            end
        end
    end

    // Sender: builds the tape, sends it and gives the verdict.
    initial begin : sender
        logic [11:0] check_word;
        int          pick;
        // Directed leader: blanks, edge bytes, a rubout pair and a field setting.
        tape_image.push_back(8'o000);
        tape_image.push_back(BYTE_EDGE);
        tape_image.push_back(8'o000);
        tape_image.push_back(BYTE_RUBOUT);
        tape_image.push_back(8'o123);
        tape_image.push_back(8'o370);
        tape_image.push_back(BYTE_EDGE);
        // Origin at the top of memory, then a full word written there in field 7.
        punch_frame(8'o177, 8'o177, 1'b0);
        punch_frame(8'o077, 8'o077, 1'b0);
        // Back to field 0; the origin wraps to zero.
        tape_image.push_back(8'o201);
        punch_frame(8'o000, 8'o000, 1'b0);
        // Low bytes that overlap the high byte: the edge value and bit 6 set.
        punch_frame(8'o000, BYTE_EDGE, 1'b0);
        tape_image.push_back(8'o001);
        tape_image.push_back(BYTE_RUBOUT);
        tape_image.push_back(BYTE_RUBOUT);
        tape_image.push_back(8'o100);
        tape_sum = tape_sum + 8'o101;
        tape_image.push_back(8'o270);
        punch_frame(8'o052, 8'o025, 1'b0);

        // Random frames with field settings and rubouts mixed in.
        while (tape_image.size() < 1250) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                punch_frame(8'($urandom_range(8'o100, 8'o177)),
                            8'($urandom_range(0, 8'o077)), 1'b1);
            end else if (pick < 18) begin
                punch_noise();
            end else if ($urandom_range(9) == 0) begin
                punch_frame(8'($urandom_range(0, 8'o077)),
                            8'($urandom_range(8'o100, 8'o200)), 1'b1);
            end else begin
                punch_frame(8'($urandom_range(0, 8'o077)),
                            8'($urandom_range(0, 8'o077)), 1'b1);
            end
        end

        // Checksum frame, right or with one bit flipped, then the trailer.
        check_word = tape_sum;
        if ($urandom_range(1) == 0) check_word = check_word ^ (12'd1 << $urandom_range(11));
        tape_image.push_back({2'b00, check_word[11:6]});
        tape_image.push_back({2'b00, check_word[5:0]});
        tape_image.push_back(BYTE_EDGE);
        // Bytes after the trailer must be ignored.
        repeat (20) tape_image.push_back(8'($urandom_range(0, 255)));

        // Reset, released at a falling edge.
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // One transfer per byte, with random idle gaps outside the calm stretch.
        foreach (tape_image[i]) begin
            calm = (i >= 300 && i < 550);
            while (!calm && $urandom_range(99) < 24) begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid  <= 1'b1;
            tape_byte <= tape_image[i];
            @(posedge clk);
            while (in_stall) @(posedge clk);
            bytes_taken++;
            @(negedge clk);
        end
        in_valid <= 1'b0;
        calm     = 1'b0;

        // Drain the outstanding results, then allow for the pipeline latency.
        while (due_count != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        if (fail_count == 0) begin
            $display("** paper_tape_bin_loader: PASSED **");
        end else begin
            $display("** paper_tape_bin_loader: FAILED **");
        end
        $finish;
    end

endmodule
